// ===== sv/sdiv_pkg.sv =====
// Shared constants, control types and helpers for the signed divider.
package sdiv_pkg;

  // Operand and result width
  localparam int unsigned DATA_WIDTH = 32;
  // Iteration counter width, one quotient bit per step
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);
  // Stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;  // capture operands, form magnitudes
    logic step;  // one restoring division step
    logic fix;   // sign fix-up into the output register
  } sdiv_ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic div_zero;  // divisor of the presented operands is zero
  } sdiv_stat_t;

  // Two's complement negate at DATA_WIDTH bits
  function automatic logic [DATA_WIDTH-1:0] neg_w(input logic [DATA_WIDTH-1:0] x);
    logic [DATA_WIDTH-1:0] one;
    one = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    return ~x + one;
  endfunction

  // Magnitude of a two's complement value, held unsigned
  function automatic logic [DATA_WIDTH-1:0] mag_w(input logic [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? neg_w(x) : x;
  endfunction

endpackage

// ===== sv/sdiv_datapath.sv =====
// Restoring divider datapath: operand magnitudes, shared subtract unit, sign fix-up.
module sdiv_datapath
  import sdiv_pkg::*;
(
  input  logic                         clk_i,
  input  sdiv_ctrl_t                   ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output sdiv_stat_t                   stat_o,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic signed [DATA_WIDTH-1:0] remainder_o,
  output logic                         divide_by_zero_o
);

  // Working registers
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;   // dividend bits shift out, quotient bits in
  logic [DATA_WIDTH-1:0] den_q, den_d;
  logic                  a_neg_q, a_neg_d;
  logic                  b_neg_q, b_neg_d;
  logic                  dz_q, dz_d;

  // Output register
  logic [DATA_WIDTH-1:0] q_out_q, q_out_d;
  logic [DATA_WIDTH-1:0] r_out_q, r_out_d;
  logic                  dz_out_q, dz_out_d;

  // Shared subtract unit
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  take;

  assign stat_o.div_zero = (divisor_i == '0);

  assign trial = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign take  = ~diff[DATA_WIDTH+1];

  // Next-state of the working registers
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    a_neg_d = a_neg_q;
    b_neg_d = b_neg_q;
    dz_d    = dz_q;
    if (ctrl_i.load) begin
      a_neg_d = dividend_i[DATA_WIDTH-1];
      b_neg_d = divisor_i[DATA_WIDTH-1];
      dz_d    = stat_o.div_zero;
      den_d   = mag_w(divisor_i);
      // zero divisor: remainder carries the raw dividend through
      rem_d   = stat_o.div_zero ? dividend_i : '0;
      quo_d   = stat_o.div_zero ? '0 : mag_w(dividend_i);
    end else if (ctrl_i.step) begin
      rem_d = take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], take};
    end
  end

  // Sign fix-up into the output register
  always_comb begin
    q_out_d  = q_out_q;
    r_out_d  = r_out_q;
    dz_out_d = dz_out_q;
    if (ctrl_i.fix) begin
      dz_out_d = dz_q;
      if (dz_q) begin
        q_out_d = '0;
        r_out_d = rem_q;
      end else begin
        q_out_d = (a_neg_q ^ b_neg_q) ? neg_w(quo_q) : quo_q;
        r_out_d = a_neg_q ? neg_w(rem_q) : rem_q;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    a_neg_q  <= a_neg_d;
    b_neg_q  <= b_neg_d;
    dz_q     <= dz_d;
    q_out_q  <= q_out_d;
    r_out_q  <= r_out_d;
    dz_out_q <= dz_out_d;
  end

  assign quotient_o       = q_out_q;
  assign remainder_o      = r_out_q;
  assign divide_by_zero_o = dz_out_q;

endmodule

// ===== sv/sdiv_ctrl.sv =====
// Sequencer: operand capture, bit iterations, fix-up and output handshake.
module sdiv_ctrl
  import sdiv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sdiv_stat_t stat_i,
  output sdiv_ctrl_t ctrl_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic             out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_free    = ~ovalid_q | out_ready_i;
  assign out_valid_o = ovalid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o      = '0;
    ovalid_d    = ovalid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d       = CNT_LAST;
          state_d     = stat_i.div_zero ? ST_FIX : ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl_o.step = 1'b1;
        cnt_d       = cnt_q - CNT_ONE;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          ctrl_o.fix = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== sv/signed_divide_with_remainder_core.sv =====
// Top level of the signed truncating divider with remainder.
// Signed divider, truncating toward zero: each transaction on the slave stream carries
// a dividend and a divisor and yields one transaction on the master stream with the
// quotient, the remainder (sign of the dividend) and a divide-by-zero flag in tuser.
// A zero divisor gives quotient 0 and remainder equal to the dividend; the most
// negative value over minus one wraps to itself. A transaction goes through capture,
// 32 restoring subtract steps on one shared subtractor and sign fix-up; a zero
// divisor skips the subtract steps. s_axis_tready is low from acceptance to result
// and also while a finished result waits for a free output register.
module signed_divide_with_remainder_core
  import sdiv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // dividend, divisor
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // quotient, remainder
  output logic                 m_axis_tuser    // divide_by_zero
);

  sdiv_ctrl_t                   ctrl;
  sdiv_stat_t                   stat;
  logic signed [DATA_WIDTH-1:0] dividend;
  logic signed [DATA_WIDTH-1:0] divisor;
  logic signed [DATA_WIDTH-1:0] quotient;
  logic signed [DATA_WIDTH-1:0] remainder;
  logic                         divide_by_zero;

  // Unpack operands
  assign dividend = s_axis_tdata[DATA_WIDTH-1:0];
  assign divisor  = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  sdiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  sdiv_datapath u_dp (
    .clk_i            (clk_i),
    .ctrl_i           (ctrl),
    .dividend_i       (dividend),
    .divisor_i        (divisor),
    .stat_o           (stat),
    .quotient_o       (quotient),
    .remainder_o      (remainder),
    .divide_by_zero_o (divide_by_zero)
  );

  // Pack results
  assign m_axis_tdata = M_TDATA_W'({remainder, quotient});
  assign m_axis_tuser = divide_by_zero;

endmodule

// ===== sv/sdiv_checker.sv =====
// Port-level assertions for the signed divider, bound to the top level.
module sdiv_checker
  import sdiv_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_tvalid_i,
  input logic                 s_tready_i,
  input logic [S_TDATA_W-1:0] s_tdata_i,
  input logic                 m_tvalid_i,
  input logic                 m_tready_i,
  input logic [M_TDATA_W-1:0] m_tdata_i,
  input logic                 m_tuser_i
);

  logic s_acc;
  logic nz_div;

  assign s_acc  = s_tvalid_i & s_tready_i;
  assign nz_div = (s_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH] != '0);

  // Busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_tready_i)
    else $error("input ready right after an accepted transaction");

  // A nonzero divisor keeps the block busy through all quotient steps
  a_busy_full_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && nz_div |-> ##32 !s_tready_i)
    else $error("divider finished before all quotient steps");

  // Zero divisor result carries a zero quotient
  a_dz_zero_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> (m_tdata_i[DATA_WIDTH-1:0] == '0))
    else $error("divide by zero with nonzero quotient");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

endmodule

bind signed_divide_with_remainder_core sdiv_checker u_sdiv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .s_tdata_i  (s_axis_tdata),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser)
);

// ===== tb/signed_divide_with_remainder_core_tb.sv =====
// Self-checking testbench for the signed truncating divider with remainder.
`timescale 1ns / 100ps

module signed_divide_with_remainder_core_tb;
  import sdiv_pkg::*;

  localparam int DW            = DATA_WIDTH;
  localparam int RANDOM_OPS    = 700;
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES   = 40;    // a bit more than one full division
  localparam int MAX_REPORTS   = 10;
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  // Operand pair; drain_first holds it back until all results are in
  typedef struct packed {
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic          drain_first;
  } div_op_t;

  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          divide_by_zero;
  } div_result_t;

  // Receiver backpressure patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  div_op_t     pending_ops[$];
  div_result_t awaited_results[$];
  div_op_t     next_op;
  div_result_t got_result;
  div_result_t want_result;

  int       tx_burst_left = 0;
  int       tx_gap_left   = 0;
  rx_mode_e rx_mode       = RX_OPEN;
  int       rx_mode_left  = 0;
  int       rx_stall_left = 0;
  int       fail_count    = 0;
  int       stuck_cycles  = 0;

  signed_divide_with_remainder_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Truncating signed division: restoring divide on magnitudes, then sign fix-up
  function automatic div_result_t divide_truncating(input logic [DW-1:0] num,
                                                    input logic [DW-1:0] den);
    div_result_t   res;
    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW-1:0] quo;
    logic [DW:0]   part;
    res.divide_by_zero = (den == '0);
    res.quotient       = '0;
    res.remainder      = num;
    if (den != '0) begin
      num_mag = num[DW-1] ? ~num + 1'b1 : num;
      den_mag = den[DW-1] ? ~den + 1'b1 : den;
      part    = '0;
      quo     = '0;
      for (int i = DW - 1; i >= 0; i--) begin
        part = {part[DW-1:0], num_mag[i]};
        quo  = quo << 1;
        if (part >= {1'b0, den_mag}) begin
          part   = part - {1'b0, den_mag};
          quo[0] = 1'b1;
        end
      end
      res.quotient  = (num[DW-1] ^ den[DW-1]) ? ~quo + 1'b1 : quo;
      res.remainder = num[DW-1] ? ~part[DW-1:0] + 1'b1 : part[DW-1:0];
    end
    return res;
  endfunction

  // Random operand drawn from a mix of shapes
  function automatic logic [DW-1:0] pick_operand();
    logic [63:0]   wide;
    logic [DW-1:0] v;
    wide = {$urandom, $urandom};
    v    = wide[DW-1:0];
    case ($urandom_range(0, 9))
      3, 4: v = $urandom_range(0, 32) - 16;
      5, 6: begin
        v = v >> $urandom_range(0, DW - 1);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
      7: begin
        case ($urandom_range(0, 5))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = '0;
          3: v = 1;
          4: v = -1;
          default: v = MOST_NEG + 1'b1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_op(input logic [DW-1:0] dividend, input logic [DW-1:0] divisor,
                        input logic drain_first);
    div_op_t op;
    op.dividend    = dividend;
    op.divisor     = divisor;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Sender: bursts of random length with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_burst_left <= 0;
      tx_gap_left   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(divide_truncating(s_axis_tdata[DW-1:0],
                                                    s_axis_tdata[2*DW-1:DW]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left   <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain_first && awaited_results.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          next_op       = pending_ops.pop_front();
          s_axis_tdata  <= {next_op.divisor, next_op.dividend};
          s_axis_tvalid <= 1'b1;
          if (tx_burst_left <= 1) begin
            tx_burst_left <= $urandom_range(1, 12);
            tx_gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 45);
          end else begin
            tx_burst_left <= tx_burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: ready pattern switches between open, coin-flip, sparse and long stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= RX_OPEN;
      rx_mode_left  <= 0;
      rx_stall_left <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
        default: begin
          if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall_left <= $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.quotient       = m_axis_tdata[DW-1:0];
      got_result.remainder      = m_axis_tdata[2*DW-1:DW];
      got_result.divide_by_zero = m_axis_tuser;
      if (awaited_results.size() == 0) begin
        log_failure($sformatf("unexpected result: quotient %0d remainder %0d div0 %b",
                              $signed(got_result.quotient), $signed(got_result.remainder),
                              got_result.divide_by_zero));
      end else begin
        want_result = awaited_results.pop_front();
        if (got_result.quotient !== want_result.quotient ||
            got_result.remainder !== want_result.remainder ||
            got_result.divide_by_zero !== want_result.divide_by_zero) begin
          log_failure($sformatf(
            "mismatch: quotient exp %0d got %0d, remainder exp %0d got %0d, div0 exp %b got %b",
            $signed(want_result.quotient), $signed(got_result.quotient),
            $signed(want_result.remainder), $signed(got_result.remainder),
            want_result.divide_by_zero, got_result.divide_by_zero));
        end
      end
    end
  end

  // Count cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  // Watchdog
  initial begin
    while (stuck_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("signed_divide_with_remainder_core test failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    // zero divisor: flag set, quotient 0, remainder is the dividend
    add_op(5, 0, 1'b0);
    add_op(-7, 0, 1'b0);
    add_op(MOST_NEG, 0, 1'b0);
    add_op(MOST_POS, 0, 1'b0);
    add_op(0, 0, 1'b0);
    // most negative over minus one wraps; other extremes
    add_op(MOST_NEG, -1, 1'b0);
    add_op(MOST_NEG, 1, 1'b0);
    add_op(MOST_NEG, MOST_NEG, 1'b0);
    add_op(MOST_NEG, MOST_POS, 1'b0);
    add_op(MOST_POS, MOST_NEG, 1'b0);
    add_op(MOST_POS, -1, 1'b0);
    add_op(MOST_POS, MOST_POS, 1'b0);
    add_op(MOST_POS, 1, 1'b0);
    add_op(MOST_NEG, 2, 1'b0);
    add_op(MOST_NEG, -2, 1'b0);
    add_op(MOST_NEG, 3, 1'b0);
    // all four sign combinations
    add_op(7, 2, 1'b0);
    add_op(-7, 2, 1'b0);
    add_op(7, -2, 1'b0);
    add_op(-7, -2, 1'b0);
    // dividend smaller than divisor, zero dividend
    add_op(0, 5, 1'b0);
    add_op(3, 7, 1'b0);
    add_op(-1, MOST_POS, 1'b0);
    add_op(1, MOST_NEG, 1'b0);
    add_op(-1, -1, 1'b0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      add_op(pick_operand(),
             ($urandom_range(0, 15) == 0) ? '0 : pick_operand(),
             (n % 175) == 0);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("signed_divide_with_remainder_core test passed");
    else
      $display("signed_divide_with_remainder_core test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sdiv_pkg.sv
sv/sdiv_datapath.sv
sv/sdiv_ctrl.sv
sv/signed_divide_with_remainder_core.sv
sv/sdiv_checker.sv
tb/signed_divide_with_remainder_core_tb.sv
